[sv/crid_pkg.sv]
// Package for the content identifier descriptor parser.
// Holds the transaction payload types and the parse phase encoding.
// No dependencies.
package crid_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} crid_in_item_t;

	typedef struct packed {
		logic [5:0]  crid_type;
		logic [1:0]  crid_location;
		logic [7:0]  crid_length;
		logic [15:0] crid_ref;
		logic [7:0]  id_byte;
		logic        byte_valid;
		logic        entry_end;
		logic        descriptor_end;
		logic        overrun;
	} crid_out_item_t;

	typedef enum logic [6:0] {
		PH_TAG  = 7'b0000001,
		PH_LEN  = 7'b0000010,
		PH_HDR  = 7'b0000100,
		PH_CLEN = 7'b0001000,
		PH_IDB  = 7'b0010000,
		PH_REFH = 7'b0100000,
		PH_REFL = 7'b1000000
	} crid_phase_t;

	localparam logic [1:0] LOC_EXPLICIT = 2'd0;
	localparam logic [1:0] LOC_REFERENCE = 2'd1;

	typedef struct packed {
		logic           fire;
		crid_out_item_t item;
	} crid_result_t;

endpackage

[sv/crid_if.sv]
// Valid/ready channel interfaces for descriptor bytes and parse results.
// Depends on crid_pkg.
interface crid_in_if;
	import crid_pkg::*;
	logic          valid;
	logic          ready;
	crid_in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface crid_out_if;
	import crid_pkg::*;
	logic           valid;
	logic           ready;
	crid_out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/crid_descriptor_parser_top.sv]
// Top level of the content identifier descriptor parser.
// Depends on crid_pkg, crid_if, crid_parse and crid_out_reg.
//
// Usage:
//   desc carries one descriptor byte per transaction; first_byte marks the
//   tag byte and restarts the parse from any point.
//   crid carries the results: one per identifier byte, per reference, per
//   empty or reserved entry, per entry truncated before any identifier byte,
//   and per empty descriptor. A byte can be taken every cycle unless crid
//   stalls. A result appears on crid the cycle after its byte is taken.
//   Bytes that cause no result leave nothing on crid.
//   When the receiver holds crid.ready low with a result waiting, desc.ready
//   drops and the pending result and parse state hold until it is taken.
//   Reset empties the result register and returns the parser to waiting
//   for a tag byte; bytes before the first tag are dropped.
module crid_descriptor_parser_top (
	input logic       clk,
	input logic       arst_n,
	crid_in_if.sink   desc,
	crid_out_if.source crid
);
	import crid_pkg::*;

	logic         take;
	logic         accept;
	crid_result_t result;

	assign desc.ready = take;
	assign accept     = desc.valid & take;

	crid_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (desc.payload),
		.result (result)
	);

	crid_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.result (result),
		.take   (take),
		.crid   (crid)
	);

endmodule

[sv/crid_parse.sv]
// Parse state machine: consumes one descriptor byte per accepted transaction
// and forms at most one result. Depends on crid_pkg.
module crid_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  crid_pkg::crid_in_item_t item,
	output crid_pkg::crid_result_t  result
);
	import crid_pkg::*;

	crid_phase_t phase_q, phase_d;
	logic [7:0]  dbl_q, dbl_d;
	logic [5:0]  type_q, type_d;
	logic [1:0]  loc_q, loc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  idl_q, idl_d;
	logic [7:0]  refh_q, refh_d;
	logic [7:0]  b;
	logic [7:0]  dbl_dec;
	logic [7:0]  idl_dec;
	logic        dend;
	logic        last;
	logic [15:0] ref_v;
	logic [7:0]  idb_v;
	logic        bv, eend, de, ovr, fire;

	assign b       = item.data_byte;
	assign dbl_dec = dbl_q - 8'd1;
	assign idl_dec = idl_q - 8'd1;
	assign dend    = (dbl_dec == 8'd0);
	assign last    = (idl_dec == 8'd0);

	always_comb begin
		phase_d = phase_q;
		dbl_d   = dbl_q;
		type_d  = type_q;
		loc_d   = loc_q;
		len_d   = len_q;
		idl_d   = idl_q;
		refh_d  = refh_q;
		fire    = 1'b0;
		ref_v   = 16'd0;
		idb_v   = 8'd0;
		bv      = 1'b0;
		eend    = 1'b0;
		de      = 1'b0;
		ovr     = 1'b0;
		if (item.first_byte) begin
			phase_d = PH_LEN;
			dbl_d   = 8'd0;
			type_d  = 6'd0;
			loc_d   = 2'd0;
			len_d   = 8'd0;
			idl_d   = 8'd0;
			refh_d  = 8'd0;
		end else begin
			unique case (phase_q)
				PH_TAG: begin
				end
				PH_LEN: begin
					dbl_d = b;
					if (b == 8'd0) begin
						phase_d = PH_TAG;
						fire    = 1'b1;
						de      = 1'b1;
					end else begin
						phase_d = PH_HDR;
					end
				end
				PH_HDR: begin
					dbl_d  = dbl_dec;
					type_d = b[7:2];
					loc_d  = b[1:0];
					len_d  = 8'd0;
					idl_d  = 8'd0;
					refh_d = 8'd0;
					if (b[1]) begin
						phase_d = dend ? PH_TAG : PH_HDR;
						fire    = 1'b1;
						eend    = 1'b1;
						de      = dend;
					end else if (dend) begin
						phase_d = PH_TAG;
						fire    = 1'b1;
						eend    = 1'b1;
						de      = 1'b1;
						ovr     = 1'b1;
					end else begin
						phase_d = (b[1:0] == LOC_EXPLICIT) ? PH_CLEN : PH_REFH;
					end
				end
				PH_CLEN: begin
					dbl_d = dbl_dec;
					len_d = b;
					idl_d = b;
					if (b == 8'd0) begin
						phase_d = dend ? PH_TAG : PH_HDR;
						fire    = 1'b1;
						eend    = 1'b1;
						de      = dend;
					end else if (dend) begin
						phase_d = PH_TAG;
						fire    = 1'b1;
						eend    = 1'b1;
						de      = 1'b1;
						ovr     = 1'b1;
					end else begin
						phase_d = PH_IDB;
					end
				end
				PH_IDB: begin
					dbl_d   = dbl_dec;
					idl_d   = idl_dec;
					phase_d = dend ? PH_TAG : (last ? PH_HDR : PH_IDB);
					fire    = 1'b1;
					idb_v   = b;
					bv      = 1'b1;
					eend    = last | dend;
					de      = dend;
					ovr     = dend & ~last;
				end
				PH_REFH: begin
					dbl_d  = dbl_dec;
					refh_d = b;
					if (dend) begin
						phase_d = PH_TAG;
						fire    = 1'b1;
						eend    = 1'b1;
						de      = 1'b1;
						ovr     = 1'b1;
					end else begin
						phase_d = PH_REFL;
					end
				end
				PH_REFL: begin
					dbl_d   = dbl_dec;
					phase_d = dend ? PH_TAG : PH_HDR;
					fire    = 1'b1;
					ref_v   = {refh_q, b};
					eend    = 1'b1;
					de      = dend;
				end
				default: begin
					phase_d = PH_TAG;
				end
			endcase
		end
	end

	always_comb begin
		result.fire                = fire;
		result.item.crid_type      = type_d;
		result.item.crid_location  = loc_d;
		result.item.crid_length    = (loc_d == LOC_EXPLICIT) ? len_d : 8'd0;
		result.item.crid_ref       = ref_v;
		result.item.id_byte        = idb_v;
		result.item.byte_valid     = bv;
		result.item.entry_end      = eend;
		result.item.descriptor_end = de;
		result.item.overrun        = ovr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			dbl_q   <= 8'd0;
			type_q  <= 6'd0;
			loc_q   <= 2'd0;
			len_q   <= 8'd0;
			idl_q   <= 8'd0;
			refh_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			dbl_q   <= dbl_d;
			type_q  <= type_d;
			loc_q   <= loc_d;
			len_q   <= len_d;
			idl_q   <= idl_d;
			refh_q  <= refh_d;
		end
	end

endmodule

[sv/crid_out_reg.sv]
// Result register between the parse logic and the result channel.
// Depends on crid_pkg and crid_if.
module crid_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  crid_pkg::crid_result_t result,
	output logic                   take,
	crid_out_if.source             crid
);
	import crid_pkg::*;

	logic           valid_q;
	crid_out_item_t item_q;

	assign take         = ~valid_q | crid.ready;
	assign crid.valid   = valid_q;
	assign crid.payload = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= accept & result.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && result.fire) begin
			item_q <= result.item;
		end
	end

endmodule

[sv/crid_checker.sv]
// Port-level checks for the descriptor parser, bound to the top level.
// Depends on crid_pkg and crid_descriptor_parser_top.
module crid_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input crid_pkg::crid_out_item_t out_item
);
	import crid_pkg::*;

	a_hold_valid : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_item : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("result changed while stalled");

	a_free_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.overrun |-> out_item.descriptor_end && out_item.entry_end)
		else $error("overrun without descriptor and entry end");

	a_loc_fields : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.crid_location != LOC_EXPLICIT |->
			out_item.crid_length == 8'd0 && !out_item.byte_valid)
		else $error("explicit fields set for non-explicit location");

endmodule

bind crid_descriptor_parser_top crid_checker u_crid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (desc.ready),
	.out_valid (crid.valid),
	.out_ready (crid.ready),
	.out_item  (crid.payload)
);
